// ----- rtl/sfc_pkg.sv -----
// Shared types, constants and helpers for the signature file carver.
// No dependencies; used by sfc_match and signature_file_carver.
package sfc_pkg;

  localparam int unsigned SigBytes = 8;
  localparam int unsigned SigW     = 8 * SigBytes;
  localparam int unsigned PosW     = $clog2(SigBytes);
  localparam int unsigned LenW     = 4;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [SigW-1:0] StartSigReset = 64'h0A1A_0A0D_474E_5089;
  localparam logic [SigW-1:0] EndSigReset   = 64'h8260_42AE_444E_4549;
  localparam logic [LenW-1:0] LenReset      = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_SIG = 3'd0,
    REG_START_LEN = 3'd1,
    REG_END_SIG   = 3'd2,
    REG_END_LEN   = 3'd3
  } cfg_reg_e;

  // Outcome of one naive compare step.
  typedef struct packed {
    logic            complete;
    logic [PosW-1:0] pos_next;
  } match_res_t;

  // Clamp a programmed length into 1..SigBytes.
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    if (len == '0) begin
      res = LenW'(1);
    end else if (len > LenW'(SigBytes)) begin
      res = LenW'(SigBytes);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // Select byte pos of a signature word.
  function automatic logic [7:0] sig_byte(input logic [SigW-1:0] sig,
                                          input logic [PosW-1:0] pos);
    logic [PosW+2:0] sh;
    sh = {pos, 3'b000};
    return sig[sh +: 8];
  endfunction

endpackage

// ----- rtl/sfc_match.sv -----
// Naive signature matcher step: compare one byte at the current position.
// Depends on sfc_pkg for widths, match_res_t and the byte helpers.
module sfc_match import sfc_pkg::*; (
  input  logic [SigW-1:0] sig_i,
  input  logic [LenW-1:0] len_i,
  input  logic [PosW-1:0] pos_i,
  input  logic [7:0]      data_byte_i,
  output match_res_t      res_o
);

  logic [LenW-1:0] len_eff;
  logic            hit;
  logic            at_end;

  assign len_eff = eff_len(len_i);
  assign hit     = (data_byte_i == sig_byte(sig_i, pos_i));
  // A shortened length can leave pos at or past the last byte.
  assign at_end  = ({1'b0, pos_i} + LenW'(1)) >= len_eff;

  always_comb begin
    res_o.complete = hit && at_end;
    if (hit && !at_end) begin
      res_o.pos_next = pos_i + PosW'(1);
    end else begin
      res_o.pos_next = '0;
    end
  end

endmodule

// ----- rtl/signature_file_carver.sv -----
// Signature file carver: scans a byte stream and emits the bytes of carved
// files, from start signature through end signature.
// Results are registered: the first result of a byte appears in the cycle after its transfer.
// Throughput while out_stall_i is low: one byte per cycle inside a file; a start
// match emits a burst of 1..8 signature bytes, one per cycle, and input waits until its last beat.
// Reset: match state cleared, outside a file; registers hold PNG signatures.
module signature_file_carver import sfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               file_start_o,
  output logic               file_end_o,
  output logic               run_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SigW-1:0]    cfg_data_i
);

  logic [SigW-1:0] head_sig_q, end_sig_q;
  logic [LenW-1:0] start_len_q, end_len_q;
  logic            inside_q;
  logic [PosW-1:0] start_pos_q, end_pos_q;

  logic            out_valid_q, file_start_q, file_end_q, run_last_q;
  logic [7:0]      out_byte_q;
  logic [PosW-1:0] beat_q;

  match_res_t      start_res, end_res;
  logic            in_accept, out_take, stage_free, cfg_we;
  logic [LenW-1:0] start_len_eff;
  logic [PosW-1:0] beat_next;

  sfc_match u_start_match (
    .sig_i       (head_sig_q),
    .len_i       (start_len_q),
    .pos_i       (start_pos_q),
    .data_byte_i (data_byte_i),
    .res_o       (start_res)
  );

  sfc_match u_end_match (
    .sig_i       (end_sig_q),
    .len_i       (end_len_q),
    .pos_i       (end_pos_q),
    .data_byte_i (data_byte_i),
    .res_o       (end_res)
  );

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign out_take      = out_valid_q && !out_stall_i;
  // Result stage can take a new item once the last beat of a run leaves.
  assign stage_free    = !out_valid_q || (run_last_q && !out_stall_i);
  assign in_stall_o    = !stage_free;
  assign in_accept     = in_valid_i && !in_stall_o;
  assign start_len_eff = eff_len(start_len_q);
  assign beat_next     = beat_q + PosW'(1);

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign file_start_o = file_start_q;
  assign file_end_o   = file_end_q;
  assign run_last_o   = run_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_sig_q  <= StartSigReset;
      start_len_q <= LenReset;
      end_sig_q   <= EndSigReset;
      end_len_q   <= LenReset;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_START_SIG: head_sig_q  <= cfg_data_i;
        REG_START_LEN: start_len_q <= cfg_data_i[LenW-1:0];
        REG_END_SIG:   end_sig_q   <= cfg_data_i;
        REG_END_LEN:   end_len_q   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      start_pos_q <= '0;
      end_pos_q   <= '0;
    end else if (in_accept) begin
      if (!inside_q) begin
        start_pos_q <= start_res.pos_next;
        inside_q    <= start_res.complete;
      end else begin
        end_pos_q <= end_res.pos_next;
        inside_q  <= !end_res.complete;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && (inside_q || start_res.complete)) begin
      out_valid_q <= 1'b1;
    end else if (out_take && run_last_q) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload: load on a new item, otherwise step through the start burst.
  always_ff @(posedge clk_i) begin
    if (in_accept && inside_q) begin
      out_byte_q   <= data_byte_i;
      file_start_q <= 1'b0;
      file_end_q   <= end_res.complete;
      run_last_q   <= 1'b1;
    end else if (in_accept && start_res.complete) begin
      out_byte_q   <= sig_byte(head_sig_q, '0);
      file_start_q <= 1'b1;
      file_end_q   <= 1'b0;
      run_last_q   <= (start_len_eff == LenW'(1));
      beat_q       <= '0;
    end else if (out_take && !run_last_q) begin
      out_byte_q   <= sig_byte(head_sig_q, beat_next);
      file_start_q <= 1'b0;
      file_end_q   <= 1'b0;
      run_last_q   <= (({1'b0, beat_next} + LenW'(1)) == start_len_eff);
      beat_q       <= beat_next;
    end
  end

  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> in_stall_o)
    else $error("input taken during a signature burst");

  a_start_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && file_start_o) |-> !file_end_o)
    else $error("file start and file end on one beat");

  a_inside_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && inside_q) |=> (out_valid_o && run_last_o && !file_start_o))
    else $error("in-file byte did not produce a single result");

  a_enter_emits_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(inside_q) |-> (out_valid_o && file_start_o))
    else $error("file entered without a start beat");

endmodule

// ----- tb/sv/signature_file_carver_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for signature_file_carver: directed and random byte
// streams against an in-file predictor of the carved output. Depends on sfc_pkg.
module signature_file_carver_tb;
  import sfc_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam logic [CfgIdxW-1:0] RegBeyondLast = CfgIdxW'(REG_END_LEN) + 1'b1;
  localparam logic [CfgIdxW-1:0] RegIdxTop     = '1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       file_start;
    logic       file_end;
    logic       run_last;
  } carve_beat_t;

  typedef struct {
    logic [CfgIdxW-1:0] idx;
    logic [SigW-1:0]    value;
  } reg_write_t;

  class carve_tracker;
    logic [SigW-1:0] head_sig;
    logic [SigW-1:0] end_sig;
    logic [LenW-1:0] start_len;
    logic [LenW-1:0] end_len;
    bit              in_file;
    logic [PosW-1:0] start_pos;
    logic [PosW-1:0] end_pos;
    carve_beat_t     carved_q[$];
    int              mismatches;

    function new();
      head_sig   = StartSigReset;
      end_sig    = EndSigReset;
      start_len  = LenReset;
      end_len    = LenReset;
      in_file    = 1'b0;
      start_pos  = '0;
      end_pos    = '0;
      mismatches = 0;
    endfunction

    function int clamp_len(logic [LenW-1:0] len);
      if (len == '0) return 1;
      if (len > LenW'(SigBytes)) return SigBytes;
      return int'(len);
    endfunction

    function logic [7:0] sig_at(logic [SigW-1:0] sig, int pos);
      return sig[8*pos +: 8];
    endfunction

    function void note_reg_write(logic [CfgIdxW-1:0] idx, logic [SigW-1:0] value);
      case (idx)
        REG_START_SIG: head_sig = value;
        REG_START_LEN: start_len = value[LenW-1:0];
        REG_END_SIG:   end_sig = value;
        REG_END_LEN:   end_len = value[LenW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the matchers by one byte and queue the carved bytes it yields.
    function void note_byte(logic [7:0] b);
      int          len;
      int          pos;
      carve_beat_t beat;
      if (!in_file) begin
        len = clamp_len(start_len);
        pos = int'(start_pos);
        if (b != sig_at(head_sig, pos)) begin
          start_pos = '0;
        end else if (pos + 1 < len) begin
          start_pos = PosW'(pos + 1);
        end else begin
          start_pos = '0;
          in_file   = 1'b1;
          for (int k = 0; k < len; k++) begin
            beat.out_byte   = sig_at(head_sig, k);
            beat.file_start = (k == 0);
            beat.file_end   = 1'b0;
            beat.run_last   = (k == len - 1);
            carved_q.push_back(beat);
          end
        end
      end else begin
        len = clamp_len(end_len);
        pos = int'(end_pos);
        beat.out_byte   = b;
        beat.file_start = 1'b0;
        beat.file_end   = 1'b0;
        beat.run_last   = 1'b1;
        if (b != sig_at(end_sig, pos)) begin
          end_pos = '0;
        end else if (pos + 1 < len) begin
          end_pos = PosW'(pos + 1);
        end else begin
          end_pos       = '0;
          in_file       = 1'b0;
          beat.file_end = 1'b1;
        end
        carved_q.push_back(beat);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 50) $display("mismatch: %s", what);
    endtask

    task check_result(carve_beat_t got);
      carve_beat_t want;
      if (carved_q.size() == 0) begin
        report($sformatf("unexpected transfer, out_byte %02h", got.out_byte));
        return;
      end
      want = carved_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      if (got.file_start !== want.file_start)
        report($sformatf("file_start got %b want %b", got.file_start, want.file_start));
      if (got.file_end !== want.file_end)
        report($sformatf("file_end got %b want %b", got.file_end, want.file_end));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last got %b want %b", got.run_last, want.run_last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [7:0]         data_byte = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SigW-1:0]    cfg_data = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [7:0]         out_byte_o;
  logic               file_start_o;
  logic               file_end_o;
  logic               run_last_o;
  logic               cfg_ready_o;

  carve_tracker sb;
  carve_beat_t  seen_beat;
  reg_write_t   cfg_plan[$];
  int           send_gap_pct = 0;
  int           stall_pct = 0;
  int           file_bytes = 0;

  signature_file_carver dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte_o),
    .file_start_o (file_start_o),
    .file_end_o   (file_end_o),
    .run_last_o   (run_last_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Track every transfer on all three channels at the edge where it happens.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o) sb.note_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall_o) sb.note_byte(data_byte);
      if (out_valid_o && !out_stall) begin
        seen_beat.out_byte   = out_byte_o;
        seen_beat.file_start = file_start_o;
        seen_beat.file_end   = file_end_o;
        seen_beat.run_last   = run_last_o;
        sb.check_result(seen_beat);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.carved_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic void plan_write(logic [CfgIdxW-1:0] idx, logic [SigW-1:0] value);
    reg_write_t w;
    w.idx   = idx;
    w.value = value;
    cfg_plan.push_back(w);
  endfunction

  task automatic apply_cfg();
    reg_write_t w;
    while (cfg_plan.size() != 0) begin
      w = cfg_plan.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.value;
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_random(input int start_len_v, input int end_len_v);
    plan_write(REG_START_SIG, {$urandom, $urandom});
    plan_write(REG_START_LEN, {$urandom, $urandom} & ~SigW'('hF) | SigW'(start_len_v));
    plan_write(REG_END_SIG, {$urandom, $urandom});
    plan_write(REG_END_LEN, SigW'(end_len_v));
    plan_write(CfgIdxW'($urandom_range(RegIdxTop, RegBeyondLast)), {$urandom, $urandom});
    apply_cfg();
  endtask

  // A byte in neither signature drops any partial match on both sides.
  function automatic logic [7:0] separator();
    logic [7:0] b;
    bit         hit;
    do begin
      b   = 8'($urandom_range(255));
      hit = 1'b0;
      for (int k = 0; k < SigBytes; k++)
        if (b == sb.head_sig[8*k +: 8] || b == sb.end_sig[8*k +: 8]) hit = 1'b1;
    end while (hit);
    return b;
  endfunction

  task automatic send_file();
    int slen;
    int elen;
    int body;
    slen = sb.clamp_len(sb.start_len);
    elen = sb.clamp_len(sb.end_len);
    body = $urandom_range(12);
    send_byte(separator());
    for (int k = 0; k < slen; k++) send_byte(sb.head_sig[8*k +: 8]);
    // Body bytes lean on the end signature to exercise partial end matches.
    for (int k = 0; k < body; k++) begin
      if ($urandom_range(3) == 0) send_byte(sb.end_sig[8*$urandom_range(SigBytes-1) +: 8]);
      else send_byte(8'($urandom_range(255)));
    end
    send_byte(separator());
    for (int k = 0; k < elen; k++) send_byte(sb.end_sig[8*k +: 8]);
    file_bytes += slen + body + elen + 2;
  endtask

  task automatic send_noise();
    int slen;
    int cut;
    int run;
    slen = sb.clamp_len(sb.start_len);
    if (slen > 1 && $urandom_range(1) == 1) begin
      // Broken start: a prefix of the signature cut off by a stray byte.
      cut = $urandom_range(slen - 1, 1);
      for (int k = 0; k < cut; k++) send_byte(sb.head_sig[8*k +: 8]);
      send_byte(separator());
    end else begin
      run = $urandom_range(6, 1);
      for (int k = 0; k < run; k++) begin
        if ($urandom_range(1) == 1) send_byte(sb.head_sig[8*$urandom_range(SigBytes-1) +: 8]);
        else send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input int gap_pct, input int hold_pct, input int target);
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    file_bytes   = 0;
    while (file_bytes < target) begin
      if ($urandom_range(9) < 7) send_file();
      else send_noise();
    end
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 7;
    stall_pct    = 51;

    // Registers out of reset: full-length default signatures.
    for (int k = 0; k < SigBytes; k++) send_byte(StartSigReset[8*k +: 8]);
    send_byte(8'hA5);
    for (int k = 0; k < SigBytes; k++) send_byte(EndSigReset[8*k +: 8]);
    wait_idle();

    // Out-of-list indexes must be ignored; zero start length acts as one,
    // an oversize end length saturates, and upper data bits are masked.
    plan_write(RegBeyondLast, '1);
    plan_write(RegIdxTop, '0);
    plan_write(REG_START_SIG, 64'h0123_4567_89AB_CD00);
    plan_write(REG_START_LEN, {{(SigW-LenW){1'b1}}, LenW'(0)});
    plan_write(REG_END_SIG, '1);
    plan_write(REG_END_LEN, '1);
    apply_cfg();
    send_byte(8'h00);
    repeat (SigBytes) send_byte(8'hFF);
    wait_idle();

    // Shorten the start length while a match is in progress.
    plan_write(REG_START_SIG, 64'hDEAD_BEEF_C0_33_22_11);
    plan_write(REG_START_LEN, SigW'(3));
    apply_cfg();
    send_byte(8'h11);
    send_byte(8'h22);
    wait_idle();
    plan_write(REG_START_LEN, SigW'(1));
    apply_cfg();
    send_byte(8'h33);
    wait_idle();

    configure_random(SigBytes, SigBytes);
    run_phase(7, 51, 55);
    wait_idle();

    configure_random($urandom_range(3), $urandom_range(3));
    run_phase(51, 7, 55);
    wait_idle();

    configure_random($urandom_range(15), $urandom_range(15));
    run_phase(0, 0, 55);
    wait_idle();

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfc_pkg.sv
rtl/sfc_match.sv
rtl/signature_file_carver.sv
tb/sv/signature_file_carver_tb.sv
